// ----- rtl/tcc_pkg.sv -----
package tcc_pkg;

   // Field widths of the channels.
   localparam int CHAR_W  = 8;
   localparam int CELL_W  = 8;
   localparam int OP_W    = 2;
   localparam int GROW_W  = 3;
   localparam int BITS_W  = 5;
   localparam int INDEX_W = 8;
   localparam int NUM_W   = 20;
   localparam int ROWS    = 7;

   // Command codes on the result channel.
   localparam logic [OP_W-1:0] OP_GLYPH  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_EOL    = 2'd2;
   localparam logic [OP_W-1:0] OP_SCROLL = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [INDEX_W-1:0] REG_TEXT_COLUMNS = 8'd0;
   localparam logic [INDEX_W-1:0] REG_TEXT_LINES   = 8'd1;

   // Register reset values.
   localparam logic [CELL_W-1:0] COLUMNS_RESET = 8'd80;
   localparam logic [CELL_W-1:0] LINES_RESET   = 8'd25;

   // Special bytes.
   localparam logic [CHAR_W-1:0] CHAR_ESC  = 8'h1b;
   localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_BS   = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_LBR  = 8'h5b;
   localparam logic [CHAR_W-1:0] CHAR_SEMI = 8'h3b;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_J    = 8'h4a;
   localparam logic [CHAR_W-1:0] CHAR_H    = 8'h48;
   localparam logic [CHAR_W-1:0] CHAR_F    = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_K    = 8'h4b;
   localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CASE_FOLD = 8'h20;

   // The decimal parameter stops growing once it exceeds this value.
   localparam logic [NUM_W-1:0] NUMBER_LIMIT = 20'd100000;

   // Emitter step numbers: glyph rows, then the tail slot.
   localparam logic [GROW_W-1:0] STEP_FIRST = 3'd0;
   localparam logic [GROW_W-1:0] STEP_LAST_ROW = 3'd6;
   localparam logic [GROW_W-1:0] STEP_TAIL = 3'd7;

   typedef logic [ROWS-1:0][BITS_W-1:0] rows_type;

   // One decoded item as handed from the decoder to the emitter.
   typedef struct packed {
      logic              valid;
      logic              glyph;
      rows_type          rows;
      logic              cmd;
      logic [OP_W-1:0]   cmd_op;
      logic [CELL_W-1:0] column;
      logic [CELL_W-1:0] line;
      logic              scroll;
   } job_type;

   function automatic rows_type pack_rows(input logic [BITS_W-1:0] r0,
                                          input logic [BITS_W-1:0] r1,
                                          input logic [BITS_W-1:0] r2,
                                          input logic [BITS_W-1:0] r3,
                                          input logic [BITS_W-1:0] r4,
                                          input logic [BITS_W-1:0] r5,
                                          input logic [BITS_W-1:0] r6);
      return {r6, r5, r4, r3, r2, r1, r0};
   endfunction

   // 5x7 font; row 0 is the top row, bit 4 the leftmost pixel.
   function automatic rows_type font_rows(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] c;
      rows_type          v;
      c = ch;
      if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
         c = ch - CASE_FOLD;
      end
      case (c)
         "0": v = pack_rows(14, 17, 19, 21, 25, 17, 14);
         "1": v = pack_rows(4, 12, 4, 4, 4, 4, 14);
         "2": v = pack_rows(14, 17, 1, 2, 4, 8, 31);
         "3": v = pack_rows(30, 1, 1, 14, 1, 1, 30);
         "4": v = pack_rows(2, 6, 10, 18, 31, 2, 2);
         "5": v = pack_rows(31, 16, 16, 30, 1, 1, 30);
         "6": v = pack_rows(14, 16, 16, 30, 17, 17, 14);
         "7": v = pack_rows(31, 1, 2, 4, 8, 8, 8);
         "8": v = pack_rows(14, 17, 17, 14, 17, 17, 14);
         "9": v = pack_rows(14, 17, 17, 15, 1, 1, 14);
         "A": v = pack_rows(14, 17, 17, 31, 17, 17, 17);
         "B": v = pack_rows(30, 17, 17, 30, 17, 17, 30);
         "C": v = pack_rows(14, 17, 16, 16, 16, 17, 14);
         "D": v = pack_rows(30, 17, 17, 17, 17, 17, 30);
         "E": v = pack_rows(31, 16, 16, 30, 16, 16, 31);
         "F": v = pack_rows(31, 16, 16, 30, 16, 16, 16);
         "G": v = pack_rows(14, 17, 16, 23, 17, 17, 15);
         "H": v = pack_rows(17, 17, 17, 31, 17, 17, 17);
         "I": v = pack_rows(14, 4, 4, 4, 4, 4, 14);
         "J": v = pack_rows(7, 2, 2, 2, 18, 18, 12);
         "K": v = pack_rows(17, 18, 20, 24, 20, 18, 17);
         "L": v = pack_rows(16, 16, 16, 16, 16, 16, 31);
         "M": v = pack_rows(17, 27, 21, 21, 17, 17, 17);
         "N": v = pack_rows(17, 25, 25, 21, 19, 19, 17);
         "O": v = pack_rows(14, 17, 17, 17, 17, 17, 14);
         "P": v = pack_rows(30, 17, 17, 30, 16, 16, 16);
         "Q": v = pack_rows(14, 17, 17, 17, 21, 18, 13);
         "R": v = pack_rows(30, 17, 17, 30, 20, 18, 17);
         "S": v = pack_rows(15, 16, 16, 14, 1, 1, 30);
         "T": v = pack_rows(31, 4, 4, 4, 4, 4, 4);
         "U": v = pack_rows(17, 17, 17, 17, 17, 17, 14);
         "V": v = pack_rows(17, 17, 17, 17, 17, 10, 4);
         "W": v = pack_rows(17, 17, 17, 21, 21, 21, 10);
         "X": v = pack_rows(17, 17, 10, 4, 10, 17, 17);
         "Y": v = pack_rows(17, 17, 10, 4, 4, 4, 4);
         "Z": v = pack_rows(31, 1, 2, 4, 8, 16, 31);
         "-": v = pack_rows(0, 0, 0, 31, 0, 0, 0);
         "_": v = pack_rows(0, 0, 0, 0, 0, 0, 31);
         ".": v = pack_rows(0, 0, 0, 0, 0, 0, 4);
         ":": v = pack_rows(0, 0, 4, 0, 0, 4, 0);
         "/": v = pack_rows(1, 0, 16, 8, 4, 2, 1);
         ">": v = pack_rows(0, 0, 16, 8, 1, 0, 0);
         "<": v = pack_rows(0, 0, 1, 2, 16, 0, 0);
         "!": v = pack_rows(4, 4, 4, 4, 4, 4, 4);
         "?": v = pack_rows(14, 17, 1, 2, 0, 0, 4);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/tcc_if.sv -----
// Input channel: one text byte per item.
interface tcc_req_if import tcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// Result channel: one display command per item.
interface tcc_rsp_if import tcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CELL_W-1:0] cell_column;
   logic [CELL_W-1:0] cell_line;
   logic [GROW_W-1:0] pixel_row;
   logic [BITS_W-1:0] row_bits;
   logic              last;
   modport source (output valid, output op, output cell_column, output cell_line,
                   output pixel_row, output row_bits, output last, input ready);
   modport sink   (input valid, input op, input cell_column, input cell_line,
                   input pixel_row, input row_bits, input last, output ready);
endinterface

// Configuration write channel.
interface tcc_csr_if import tcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [CELL_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tcc_decode.sv -----
// Escape parser and cursor tracking. Decodes one accepted byte into a job
// for the emitter and updates the cursor and parser state on the same edge.
module tcc_decode import tcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CHAR_W-1:0] char_code,
   input  logic [CELL_W-1:0] text_columns,
   input  logic [CELL_W-1:0] text_lines,
   output job_type           job
);

   localparam logic [1:0] PHASE_TEXT = 2'd0;
   localparam logic [1:0] PHASE_ESC  = 2'd1;
   localparam logic [1:0] PHASE_CSI  = 2'd2;

   logic [CELL_W-1:0] column_ff, column_in;
   logic [CELL_W-1:0] line_ff, line_in;
   logic [1:0]        phase_ff, phase_in;
   logic [NUM_W-1:0]  number_ff, number_in;

   // One extra bit: a line feed plus a forced wrap can step the line twice.
   logic [CELL_W:0] col_v;
   logic [CELL_W:0] line_v;
   logic            checks;
   logic            is_digit;

   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

   always_comb begin
      col_v     = {1'b0, column_ff};
      line_v    = {1'b0, line_ff};
      phase_in  = phase_ff;
      number_in = number_ff;
      checks    = 1'b0;
      job       = '0;
      case (phase_ff)
         PHASE_TEXT: begin
            if (char_code == CHAR_ESC) begin
               phase_in = PHASE_ESC;
            end else if (char_code == CHAR_CR) begin
               col_v = '0;
            end else begin
               checks = 1'b1;
               if (char_code == CHAR_LF) begin
                  col_v  = '0;
                  line_v = line_v + 1'b1;
               end else if (char_code == CHAR_BS) begin
                  if (column_ff != '0) begin
                     col_v = col_v - 1'b1;
                  end
               end else begin
                  job.glyph  = 1'b1;
                  job.rows   = font_rows(char_code);
                  job.column = column_ff;
                  job.line   = line_ff;
                  col_v      = col_v + 1'b1;
               end
            end
         end
         PHASE_ESC: begin
            if (char_code == CHAR_LBR) begin
               phase_in  = PHASE_CSI;
               number_in = '0;
            end else begin
               phase_in = PHASE_TEXT;
            end
         end
         default: begin
            // Inside a control sequence.
            if (is_digit) begin
               if (number_ff <= NUMBER_LIMIT) begin
                  number_in = (number_ff << 3) + (number_ff << 1)
                            + {{(NUM_W-4){1'b0}}, char_code[3:0]};
               end
            end else if (char_code != CHAR_SEMI) begin
               if (char_code == CHAR_J) begin
                  if (number_ff == NUM_W'(0) || number_ff == NUM_W'(2)) begin
                     job.cmd    = 1'b1;
                     job.cmd_op = OP_CLEAR;
                     col_v      = '0;
                     line_v     = '0;
                  end
               end else if (char_code == CHAR_H || char_code == CHAR_F) begin
                  col_v  = '0;
                  line_v = '0;
               end else if (char_code == CHAR_K) begin
                  job.cmd    = 1'b1;
                  job.cmd_op = OP_EOL;
                  job.column = column_ff;
                  job.line   = line_ff;
               end
               phase_in  = PHASE_TEXT;
               number_in = '0;
            end
         end
      endcase

      // Column wrap, then scroll at the bottom line.
      if (checks) begin
         if (col_v >= {1'b0, text_columns}) begin
            col_v  = '0;
            line_v = line_v + 1'b1;
         end
         if (line_v >= {1'b0, text_lines}) begin
            job.scroll = 1'b1;
            line_v     = (text_lines != '0) ? ({1'b0, text_lines} - 1'b1) : '0;
         end
      end
      job.valid = job.glyph | job.cmd | job.scroll;
      column_in = col_v[CELL_W-1:0];
      line_in   = line_v[CELL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         line_ff   <= '0;
         phase_ff  <= PHASE_TEXT;
         number_ff <= '0;
      end else if (accept) begin
         column_ff <= column_in;
         line_ff   <= line_in;
         phase_ff  <= phase_in;
         number_ff <= number_in;
      end
   end

endmodule

// ----- rtl/tcc_emit.sv -----
// Holds one decoded job and plays it out as commands into the output
// register, one per cycle unless the receiver stalls it. Glyph rows come
// first, then the tail slot carries a scroll or a single escape command.
module tcc_emit import tcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  job_type job_new,
   output logic    can_take,
   tcc_rsp_if.source rsp
);

   job_type           job_ff, job_in;
   logic [GROW_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [CELL_W-1:0] col_ff, col_in;
   logic [CELL_W-1:0] line_ff, line_in;
   logic [GROW_W-1:0] grow_ff, grow_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              last_ff, last_in;
   logic              advance;
   logic              done;

   // A command moves out when the output register is free or being drained.
   assign advance  = job_ff.valid && (!out_valid_ff || rsp.ready);
   assign done     = advance && last_in;
   assign can_take = !job_ff.valid || done;

   // Command for the current step.
   always_comb begin
      op_in   = OP_GLYPH;
      col_in  = job_ff.column;
      line_in = job_ff.line;
      grow_in = step_ff;
      bits_in = job_ff.rows[step_ff];
      last_in = (step_ff == STEP_LAST_ROW) && !job_ff.scroll;
      if (step_ff == STEP_TAIL) begin
         grow_in = '0;
         bits_in = '0;
         last_in = 1'b1;
         if (job_ff.cmd) begin
            op_in = job_ff.cmd_op;
         end else begin
            op_in   = OP_SCROLL;
            col_in  = '0;
            line_in = '0;
         end
      end
   end

   // Job register and step counter.
   always_comb begin
      job_in  = job_ff;
      step_in = step_ff;
      if (load) begin
         job_in  = job_new;
         step_in = job_new.glyph ? STEP_FIRST : STEP_TAIL;
      end else if (done) begin
         job_in.valid = 1'b0;
      end else if (advance) begin
         step_in = step_ff + 1'b1;
      end
   end

   assign out_valid_in = advance | (out_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_ff.valid <= job_in.valid;
         out_valid_ff <= out_valid_in;
      end
      job_ff.glyph  <= job_in.glyph;
      job_ff.rows   <= job_in.rows;
      job_ff.cmd    <= job_in.cmd;
      job_ff.cmd_op <= job_in.cmd_op;
      job_ff.column <= job_in.column;
      job_ff.line   <= job_in.line;
      job_ff.scroll <= job_in.scroll;
      step_ff       <= step_in;
      if (advance) begin
         op_ff   <= op_in;
         col_ff  <= col_in;
         line_ff <= line_in;
         grow_ff <= grow_in;
         bits_ff <= bits_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.op          = op_ff;
   assign rsp.cell_column = col_ff;
   assign rsp.cell_line   = line_ff;
   assign rsp.pixel_row   = grow_ff;
   assign rsp.row_bits    = bits_ff;
   assign rsp.last        = last_ff;

endmodule

// ----- rtl/text_console_command_generator_unit.sv -----
// Text console command generator. Each byte on the req channel is parsed
// against the cursor and a small ANSI escape subset (CR, LF, backspace,
// ESC [ n J, H, f, K), and the display commands it causes appear on the rsp
// channel, the final one of each byte flagged by last. A drawn byte gives
// its seven glyph rows, followed by a scroll when it also scrolls; a byte
// that causes a single command gives that one, and a silent byte is taken
// with no result. The single result port hands out one command per cycle
// while the receiver keeps up. The next byte is decoded and accepted in the
// cycle its predecessor's last command moves to the output register, so
// bytes follow without gaps. text_columns and text_lines are written on the
// csr channel (index 0 and 1); the user must do so only while no byte is in
// flight; the block does not enforce it. The write channel is always ready.
module text_console_command_generator_unit import tcc_pkg::*; (
   input logic       clock,
   input logic       reset,
   tcc_req_if.sink   req_chan,
   tcc_rsp_if.source rsp_chan,
   tcc_csr_if.sink   csr_chan
);

   logic [CELL_W-1:0] columns_ff;
   logic [CELL_W-1:0] lines_ff;
   logic              can_take;
   logic              accept;
   job_type           job;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = can_take;
   assign accept         = req_chan.valid && can_take;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         lines_ff   <= LINES_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == REG_TEXT_COLUMNS) begin
            columns_ff <= csr_chan.data;
         end
         if (csr_chan.index == REG_TEXT_LINES) begin
            lines_ff <= csr_chan.data;
         end
      end
   end

   tcc_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_code    (req_chan.char_code),
      .text_columns (columns_ff),
      .text_lines   (lines_ff),
      .job          (job)
   );

   tcc_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (accept && job.valid),
      .job_new  (job),
      .can_take (can_take),
      .rsp      (rsp_chan)
   );

endmodule

// ----- tb/sv/console_command_checker.sv -----
`timescale 1ns / 100ps

// Watches the three channels of the text console command generator. It keeps
// its own copy of the cursor, the escape parser and the screen size, works out
// the display commands of every accepted item and compares each command that
// the block hands out with the oldest one still expected.
module console_command_checker import tcc_pkg::*; (
   input  logic clock,
   input  logic reset,
   tcc_req_if   req_mon,
   tcc_rsp_if   rsp_mon,
   tcc_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CELL_W-1:0] column;
      logic [CELL_W-1:0] line;
      logic [GROW_W-1:0] pixel_row;
      logic [BITS_W-1:0] row_bits;
      logic              last;
   } console_cmd_type;

   // Parser phases. The spare code is never entered and would behave like
   // the CSI phase.
   localparam logic [1:0] PARSE_TEXT = 2'd0;
   localparam logic [1:0] PARSE_ESC  = 2'd1;
   localparam logic [1:0] PARSE_CSI  = 2'd2;

   console_cmd_type   expected_cmds [$];
   logic [CELL_W-1:0] screen_columns;
   logic [CELL_W-1:0] screen_lines;
   logic [CELL_W-1:0] cursor_col;
   logic [CELL_W-1:0] cursor_row;
   logic [1:0]        phase;
   logic [NUM_W-1:0]  csi_number;

   function automatic logic [5*ROWS-1:0] stack_rows(input logic [BITS_W-1:0] r0,
                                                    input logic [BITS_W-1:0] r1,
                                                    input logic [BITS_W-1:0] r2,
                                                    input logic [BITS_W-1:0] r3,
                                                    input logic [BITS_W-1:0] r4,
                                                    input logic [BITS_W-1:0] r5,
                                                    input logic [BITS_W-1:0] r6);
      return {r0, r1, r2, r3, r4, r5, r6};
   endfunction

   // Pixel row of the 5x7 font; lower case folds to upper case and bytes
   // without a glyph give empty rows.
   function automatic logic [BITS_W-1:0] glyph_bits(input logic [CHAR_W-1:0] ch,
                                                    input int row);
      logic [CHAR_W-1:0]  up;
      logic [5*ROWS-1:0]  rows;
      up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
      case (up)
         "0": rows = stack_rows(14, 17, 19, 21, 25, 17, 14);
         "1": rows = stack_rows(4, 12, 4, 4, 4, 4, 14);
         "2": rows = stack_rows(14, 17, 1, 2, 4, 8, 31);
         "3": rows = stack_rows(30, 1, 1, 14, 1, 1, 30);
         "4": rows = stack_rows(2, 6, 10, 18, 31, 2, 2);
         "5": rows = stack_rows(31, 16, 16, 30, 1, 1, 30);
         "6": rows = stack_rows(14, 16, 16, 30, 17, 17, 14);
         "7": rows = stack_rows(31, 1, 2, 4, 8, 8, 8);
         "8": rows = stack_rows(14, 17, 17, 14, 17, 17, 14);
         "9": rows = stack_rows(14, 17, 17, 15, 1, 1, 14);
         "A": rows = stack_rows(14, 17, 17, 31, 17, 17, 17);
         "B": rows = stack_rows(30, 17, 17, 30, 17, 17, 30);
         "C": rows = stack_rows(14, 17, 16, 16, 16, 17, 14);
         "D": rows = stack_rows(30, 17, 17, 17, 17, 17, 30);
         "E": rows = stack_rows(31, 16, 16, 30, 16, 16, 31);
         "F": rows = stack_rows(31, 16, 16, 30, 16, 16, 16);
         "G": rows = stack_rows(14, 17, 16, 23, 17, 17, 15);
         "H": rows = stack_rows(17, 17, 17, 31, 17, 17, 17);
         "I": rows = stack_rows(14, 4, 4, 4, 4, 4, 14);
         "J": rows = stack_rows(7, 2, 2, 2, 18, 18, 12);
         "K": rows = stack_rows(17, 18, 20, 24, 20, 18, 17);
         "L": rows = stack_rows(16, 16, 16, 16, 16, 16, 31);
         "M": rows = stack_rows(17, 27, 21, 21, 17, 17, 17);
         "N": rows = stack_rows(17, 25, 25, 21, 19, 19, 17);
         "O": rows = stack_rows(14, 17, 17, 17, 17, 17, 14);
         "P": rows = stack_rows(30, 17, 17, 30, 16, 16, 16);
         "Q": rows = stack_rows(14, 17, 17, 17, 21, 18, 13);
         "R": rows = stack_rows(30, 17, 17, 30, 20, 18, 17);
         "S": rows = stack_rows(15, 16, 16, 14, 1, 1, 30);
         "T": rows = stack_rows(31, 4, 4, 4, 4, 4, 4);
         "U": rows = stack_rows(17, 17, 17, 17, 17, 17, 14);
         "V": rows = stack_rows(17, 17, 17, 17, 17, 10, 4);
         "W": rows = stack_rows(17, 17, 17, 21, 21, 21, 10);
         "X": rows = stack_rows(17, 17, 10, 4, 10, 17, 17);
         "Y": rows = stack_rows(17, 17, 10, 4, 4, 4, 4);
         "Z": rows = stack_rows(31, 1, 2, 4, 8, 16, 31);
         "-": rows = stack_rows(0, 0, 0, 31, 0, 0, 0);
         "_": rows = stack_rows(0, 0, 0, 0, 0, 0, 31);
         ".": rows = stack_rows(0, 0, 0, 0, 0, 0, 4);
         ":": rows = stack_rows(0, 0, 4, 0, 0, 4, 0);
         "/": rows = stack_rows(1, 0, 16, 8, 4, 2, 1);
         ">": rows = stack_rows(0, 0, 16, 8, 1, 0, 0);
         "<": rows = stack_rows(0, 0, 1, 2, 16, 0, 0);
         // The exclamation mark is drawn as a plain vertical bar.
         "!": rows = stack_rows(4, 4, 4, 4, 4, 4, 4);
         "?": rows = stack_rows(14, 17, 1, 2, 0, 0, 4);
         default: rows = '0;
      endcase
      return rows[5*ROWS-1-5*row -: BITS_W];
   endfunction

   function automatic console_cmd_type make_cmd(input logic [OP_W-1:0]   op,
                                                input logic [CELL_W-1:0] column,
                                                input logic [CELL_W-1:0] line,
                                                input logic [GROW_W-1:0] pixel_row,
                                                input logic [BITS_W-1:0] row_bits);
      console_cmd_type cmd;
      cmd.op        = op;
      cmd.column    = column;
      cmd.line      = line;
      cmd.pixel_row = pixel_row;
      cmd.row_bits  = row_bits;
      cmd.last      = 1'b0;
      return cmd;
   endfunction

   // Advances the console state by one text byte and queues the commands
   // it causes, the final one flagged as last.
   task automatic predict_commands(input logic [CHAR_W-1:0] ch);
      console_cmd_type cmds [$];
      logic [CELL_W:0] col_next;
      logic [CELL_W:0] line_next;
      logic [31:0]     number_next;
      bit              move_cursor;
      move_cursor = 1'b0;
      case (phase)
         PARSE_TEXT: begin
            if (ch == CHAR_ESC) begin
               phase = PARSE_ESC;
            end else if (ch == CHAR_CR) begin
               cursor_col = '0;
            end else begin
               move_cursor = 1'b1;
            end
         end
         PARSE_ESC: begin
            if (ch == CHAR_LBR) begin
               phase      = PARSE_CSI;
               csi_number = '0;
            end else begin
               phase = PARSE_TEXT;
            end
         end
         default: begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
               // The parameter stops growing once it is past the cap.
               if (csi_number <= NUMBER_LIMIT) begin
                  number_next = csi_number * 10 + (ch - CHAR_ZERO);
                  csi_number  = number_next[NUM_W-1:0];
               end
            end else if (ch != CHAR_SEMI) begin
               if (ch == CHAR_J) begin
                  if (csi_number == 0 || csi_number == 2) begin
                     cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0));
                     cursor_col = '0;
                     cursor_row = '0;
                  end
               end else if (ch == CHAR_H || ch == CHAR_F) begin
                  cursor_col = '0;
                  cursor_row = '0;
               end else if (ch == CHAR_K) begin
                  cmds.push_back(make_cmd(OP_EOL, cursor_col, cursor_row, 0, 0));
               end
               phase      = PARSE_TEXT;
               csi_number = '0;
            end
         end
      endcase

      // Line feed, backspace and drawn bytes move the cursor, then wrap
      // and scroll are checked.
      if (move_cursor) begin
         col_next  = {1'b0, cursor_col};
         line_next = {1'b0, cursor_row};
         if (ch == CHAR_LF) begin
            col_next  = '0;
            line_next = line_next + 1'b1;
         end else if (ch == CHAR_BS) begin
            if (col_next != 0) begin
               col_next = col_next - 1'b1;
            end
         end else begin
            for (int r = 0; r < ROWS; r++) begin
               cmds.push_back(make_cmd(OP_GLYPH, cursor_col, cursor_row, GROW_W'(r),
                                       glyph_bits(ch, r)));
            end
            col_next = col_next + 1'b1;
         end
         if (col_next >= {1'b0, screen_columns}) begin
            col_next  = '0;
            line_next = line_next + 1'b1;
         end
         if (line_next >= {1'b0, screen_lines}) begin
            cmds.push_back(make_cmd(OP_SCROLL, 0, 0, 0, 0));
            line_next = (screen_lines != 0) ? {1'b0, screen_lines} - 1'b1 : '0;
         end
         cursor_col = col_next[CELL_W-1:0];
         cursor_row = line_next[CELL_W-1:0];
      end

      if (cmds.size() > 0) begin
         cmds[cmds.size()-1].last = 1'b1;
      end
      foreach (cmds[i]) begin
         expected_cmds.push_back(cmds[i]);
      end
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Results are checked before the item of the same edge is predicted, so a
   // command can only match bytes accepted earlier.
   always @(posedge clock) begin
      console_cmd_type want;
      if (reset) begin
         screen_columns = COLUMNS_RESET;
         screen_lines   = LINES_RESET;
         cursor_col     = '0;
         cursor_row     = '0;
         phase          = PARSE_TEXT;
         csi_number     = '0;
         expected_cmds.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_TEXT_COLUMNS: screen_columns = csr_mon.data;
               REG_TEXT_LINES:   screen_lines   = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected command, expected none, actual op %0d", $time,
                        rsp_mon.op);
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               check_field("op", want.op, rsp_mon.op);
               check_field("cell_column", want.column, rsp_mon.cell_column);
               check_field("cell_line", want.line, rsp_mon.cell_line);
               check_field("pixel_row", want.pixel_row, rsp_mon.pixel_row);
               check_field("row_bits", want.row_bits, rsp_mon.row_bits);
               check_field("last", want.last, rsp_mon.last);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_commands(req_mon.char_code);
         end
      end
      pending_count = expected_cmds.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import tcc_pkg::*;

   localparam int      CLOCK_PERIOD    = 20;
   localparam int      RESET_CYCLES    = 11;
   localparam int      IDLE_PERCENT    = 19;
   localparam int      HOLD_CYCLES     = 400;
   localparam int      SETTLE_CYCLES   = 8;
   localparam int      ITEMS_PER_PHASE = 24;
   localparam longint  TIMEOUT_CYCLES  = 200000;

   // Screen sizes used one after another, extremes among them.
   localparam int NUM_PHASES = 10;
   localparam logic [CELL_W-1:0] PHASE_COLUMNS [NUM_PHASES] =
      '{1, 255, 3, 0, 7, 255, 1, 16, 40, 80};
   localparam logic [CELL_W-1:0] PHASE_LINES [NUM_PHASES] =
      '{1, 255, 2, 0, 4, 1, 255, 5, 10, 25};
   localparam int STEADY_PHASE = 2;
   localparam int HOLD_PHASE   = 4;

   logic clock;
   logic reset;
   bit   steady;
   bit   hold_request;
   int   fail_count;
   int   pending_count;

   // Opening text: drawn extremes, cursor controls and every escape form but ESC [ f.
   logic [CHAR_W-1:0] opening_text [25] = '{
      "A", "z", "!", 8'h00, 8'hff, CHAR_CR, CHAR_LF, CHAR_BS,
      CHAR_ESC, CHAR_LBR, "2", CHAR_J,
      CHAR_ESC, CHAR_LBR, CHAR_K,
      CHAR_ESC, "x",
      CHAR_ESC, CHAR_LBR, "7", CHAR_J,
      CHAR_ESC, CHAR_LBR, CHAR_SEMI, CHAR_H
   };

   tcc_req_if req_chan ();
   tcc_rsp_if rsp_chan ();
   tcc_csr_if csr_chan ();

   text_console_command_generator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   console_command_checker cmd_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Receiver: random back-pressure, or one long hold-off when requested.
   initial begin
      bit hold_done;
      hold_done      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("FAIL text_console_command_generator_unit");
      $finish;
   end

   // Offers one item after random idle cycles and returns at the falling edge
   // after it was taken, leaving valid high for a following item.
   task automatic send_char(input logic [CHAR_W-1:0] ch);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= ch;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected command has come, then waits
   // SETTLE_CYCLES more for a silent byte still in flight.
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [CELL_W-1:0] columns,
                            input logic [CELL_W-1:0] lines);
      for (int i = 0; i < 2; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= (i == 0) ? REG_TEXT_COLUMNS : REG_TEXT_LINES;
         csr_chan.data  <= (i == 0) ? columns : lines;
         do @(posedge clock); while (!csr_chan.ready);
         @(negedge clock);
      end
      csr_chan.valid <= 1'b0;
   endtask

   // A CSI sequence with random parameter; the final byte is J, H, f or K or,
   // at times, any byte. Long digit runs push the parameter past its cap.
   task automatic send_csi();
      int digits;
      send_char(CHAR_ESC);
      send_char(CHAR_LBR);
      digits = ($urandom_range(9) == 0) ? 8 : $urandom_range(2);
      for (int i = 0; i < digits; i++) begin
         if ($urandom_range(5) == 0) begin
            send_char(CHAR_SEMI);
         end
         send_char($urandom_range(1) ? CHAR_W'(CHAR_ZERO + $urandom_range(9))
                                     : CHAR_W'(CHAR_ZERO + 2));
      end
      case ($urandom_range(5))
         0, 1:    send_char(CHAR_J);
         2:       send_char(CHAR_H);
         3:       send_char(CHAR_F);
         4:       send_char(CHAR_K);
         default: send_char(CHAR_W'($urandom_range(255)));
      endcase
   endtask

   // Mostly printable text, cursor controls and CSI sequences, the rest broken
   // escapes and arbitrary bytes.
   task automatic send_random_text();
      int kind;
      kind = $urandom_range(99);
      if (kind < 45) begin
         send_char(CHAR_W'($urandom_range(8'h7e, 8'h20)));
      end else if (kind < 55) begin
         case ($urandom_range(2))
            0:       send_char(CHAR_CR);
            1:       send_char(CHAR_LF);
            default: send_char(CHAR_BS);
         endcase
      end else if (kind < 80) begin
         send_csi();
      end else if (kind < 85) begin
         send_char(CHAR_ESC);
         send_char(CHAR_W'($urandom_range(255)));
      end else begin
         send_char(CHAR_W'($urandom_range(255)));
      end
   endtask

   initial begin
      reset              = 1'b1;
      steady             = 1'b0;
      hold_request       = 1'b0;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Opening text on the reset screen size.
      foreach (opening_text[i]) begin
         send_char(opening_text[i]);
      end
      settle();

      // Random text on each screen size; one phase runs without idling and
      // one holds the receiver off so the block fills up.
      for (int p = 0; p < NUM_PHASES; p++) begin
         configure(PHASE_COLUMNS[p], PHASE_LINES[p]);
         steady       = (p == STEADY_PHASE);
         hold_request = (p == HOLD_PHASE);
         repeat (ITEMS_PER_PHASE) send_random_text();
         settle();
      end
      steady       = 1'b0;
      hold_request = 1'b0;

      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS text_console_command_generator_unit");
      end else begin
         $display("FAIL text_console_command_generator_unit");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_decode.sv
rtl/tcc_emit.sv
rtl/text_console_command_generator_unit.sv
tb/sv/console_command_checker.sv
tb/sv/tb_top.sv
